// File: rtl/bpt_pkg.sv
// ----------------------------------------------------------------------------
// bpt_pkg
// Shared widths, register indexes and inter-stage types for the barometric
// pressure and temperature compensation pipeline.
// ----------------------------------------------------------------------------
package bpt_pkg;

  // port widths
  localparam int RAW_W     = 24;
  localparam int COEF_W    = 16;
  localparam int PRES_W    = 18;
  localparam int TOUT_W    = 16;
  localparam int CFG_IDX_W = 3;

  // internal arithmetic widths
  localparam int DT_W    = RAW_W + 1;          // D2 - C5*256
  localparam int MUL_W   = DT_W + COEF_W + 1;  // dT times a coefficient
  localparam int DD_W    = 2 * DT_W;           // dT squared
  localparam int TEMP_SH = 23;
  localparam int OFF_SH  = 7;
  localparam int SENS_SH = 8;
  localparam int T2_SH   = 31;
  localparam int A_W     = MUL_W - TEMP_SH;    // TEMP - 2000
  localparam int TEMP_W  = A_W + 1;
  localparam int T2_W    = DD_W - 1 - T2_SH;
  localparam int OFF1_W  = MUL_W - OFF_SH + 1;
  localparam int SENS1_W = MUL_W - SENS_SH + 1;
  localparam int SQ_W    = 2 * A_W;
  localparam int CORR_W  = SQ_W + 4;
  localparam int TF_W    = TEMP_W + 1;
  localparam int OFF_W   = CORR_W + 1;
  localparam int SENS_W  = CORR_W + 1;
  localparam int SPLIT_W = 22;                 // low part of SENS per multiply
  localparam int HI_W    = SENS_W - SPLIT_W;
  localparam int PL_W    = RAW_W + SPLIT_W;
  localparam int PH_W    = RAW_W + 1 + HI_W;
  localparam int SUM_W   = PH_W + SPLIT_W;
  localparam int P_SH1   = 21;
  localparam int P_SH2   = 15;
  localparam int PROD_W  = SUM_W - P_SH1;
  localparam int X_W     = PROD_W + 1;

  localparam int TEMP_REF  = 2000;
  localparam int COLD_OFS  = 3500;  // -1500 relative to 2000
  localparam int OFF2_SH   = 1;
  localparam int SENS2_SH  = 2;

  localparam int FRONT_STAGES = 3;
  localparam int CORR_STAGES  = 3;
  localparam int PRESS_STAGES = 4;
  localparam int PIPE_DEPTH   = FRONT_STAGES + CORR_STAGES + PRESS_STAGES;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SENS,
    CFG_OFFSET,
    CFG_TCS,
    CFG_TCO,
    CFG_TREF,
    CFG_TEMPSENS
  } cfg_idx_t;

  typedef struct packed {
    logic [COEF_W-1:0] sens;
    logic [COEF_W-1:0] offset;
    logic [COEF_W-1:0] tcs;
    logic [COEF_W-1:0] tco;
    logic [COEF_W-1:0] tref;
    logic [COEF_W-1:0] tempsens;
  } coeff_t;

  typedef struct packed {
    logic [RAW_W-1:0]   d1;
    logic [A_W-1:0]     a;      // TEMP - 2000, two's complement
    logic [TEMP_W-1:0]  temp;
    logic [T2_W-1:0]    t2;
    logic [OFF1_W-1:0]  off1;
    logic [SENS1_W-1:0] sens1;
  } front_t;

  typedef struct packed {
    logic [RAW_W-1:0]  d1;
    logic [TF_W-1:0]   tf;
    logic [OFF_W-1:0]  off;
    logic [SENS_W-1:0] sens;
  } corr_t;

endpackage

// File: rtl/bpt_in_if.sv
// ----------------------------------------------------------------------------
// bpt_in_if
// Raw conversion pair channel: valid/ready with D1 and D2 payload.
// ----------------------------------------------------------------------------
interface bpt_in_if;
  import bpt_pkg::*;

  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_pressure;
  logic [RAW_W-1:0] raw_temperature;

  modport source (output valid, output raw_pressure, output raw_temperature, input ready);
  modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

// File: rtl/bpt_out_if.sv
// ----------------------------------------------------------------------------
// bpt_out_if
// Compensated result channel: valid/ready with pressure and temperature.
// ----------------------------------------------------------------------------
interface bpt_out_if;
  import bpt_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [PRES_W-1:0]        pressure_out;
  logic signed [TOUT_W-1:0] temperature_out;

  modport source (output valid, output pressure_out, output temperature_out, input ready);
  modport sink   (input valid, input pressure_out, input temperature_out, output ready);
endinterface

// File: rtl/bpt_cfg_regs.sv
// ----------------------------------------------------------------------------
// bpt_cfg_regs
// Factory coefficient registers, written by index; unknown indexes dropped.
// ----------------------------------------------------------------------------
module bpt_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [bpt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bpt_pkg::COEF_W-1:0]     cfg_wdata,
  output bpt_pkg::coeff_t                coeff
);
  import bpt_pkg::*;

  coeff_t coeff_r, coeff_nxt;

  always_comb begin
    coeff_nxt = coeff_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_SENS:     coeff_nxt.sens     = cfg_wdata;
        CFG_OFFSET:   coeff_nxt.offset   = cfg_wdata;
        CFG_TCS:      coeff_nxt.tcs      = cfg_wdata;
        CFG_TCO:      coeff_nxt.tco      = cfg_wdata;
        CFG_TREF:     coeff_nxt.tref     = cfg_wdata;
        CFG_TEMPSENS: coeff_nxt.tempsens = cfg_wdata;
        default:      coeff_nxt = coeff_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coeff_r <= '0;
    end else begin
      coeff_r <= coeff_nxt;
    end
  end

  assign coeff = coeff_r;
endmodule

// File: rtl/bpt_front.sv
// ----------------------------------------------------------------------------
// bpt_front
// First-order stages: dT, the four dT products, then TEMP, OFF and SENS.
// ----------------------------------------------------------------------------
module bpt_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bpt_pkg::coeff_t             coeff,
  input  logic                        up_valid,
  output logic                        up_ready,
  input  logic [bpt_pkg::RAW_W-1:0]   d1,
  input  logic [bpt_pkg::RAW_W-1:0]   d2,
  output logic                        dn_valid,
  input  logic                        dn_ready,
  output bpt_pkg::front_t             dn_data
);
  import bpt_pkg::*;

  logic s1_v_r, s2_v_r, s3_v_r;
  logic en1, en2, en3;

  // stage 1
  logic [RAW_W-1:0]        s1_d1_r;
  logic signed [DT_W-1:0]  dt_r, dt_nxt;
  // stage 2
  logic [RAW_W-1:0]        s2_d1_r;
  logic signed [MUL_W-1:0] mt_r, mo_r, ms_r, mt_nxt, mo_nxt, ms_nxt;
  logic signed [DD_W-1:0]  dd;
  logic [T2_W-1:0]         s2_t2_r;
  // stage 3
  front_t                  s3_r, s3_nxt;

  assign en3      = !s3_v_r || dn_ready;
  assign en2      = !s2_v_r || en3;
  assign en1      = !s1_v_r || en2;
  assign up_ready = en1;

  assign dt_nxt = $signed({1'b0, d2}) - $signed({1'b0, coeff.tref, 8'h00});

  assign mt_nxt = dt_r * $signed({1'b0, coeff.tempsens});
  assign mo_nxt = dt_r * $signed({1'b0, coeff.tco});
  assign ms_nxt = dt_r * $signed({1'b0, coeff.tcs});
  assign dd     = dt_r * dt_r;

  always_comb begin
    s3_nxt.d1    = s2_d1_r;
    s3_nxt.a     = mt_r[MUL_W-1:TEMP_SH];
    s3_nxt.temp  = {s3_nxt.a[A_W-1], s3_nxt.a} + TEMP_W'(TEMP_REF);
    s3_nxt.t2    = s2_t2_r;
    s3_nxt.off1  = {{(OFF1_W-COEF_W-16){1'b0}}, coeff.offset, 16'h0000}
                 + {mo_r[MUL_W-1], mo_r[MUL_W-1:OFF_SH]};
    s3_nxt.sens1 = {{(SENS1_W-COEF_W-15){1'b0}}, coeff.sens, 15'h0000}
                 + {ms_r[MUL_W-1], ms_r[MUL_W-1:SENS_SH]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (en1) s1_v_r <= up_valid;
      if (en2) s2_v_r <= s1_v_r;
      if (en3) s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_d1_r <= d1;
      dt_r    <= dt_nxt;
    end
    if (en2) begin
      s2_d1_r <= s1_d1_r;
      mt_r    <= mt_nxt;
      mo_r    <= mo_nxt;
      ms_r    <= ms_nxt;
      // dT squared is never negative, so a plain slice is the shift
      s2_t2_r <= dd[T2_SH+T2_W-1:T2_SH];
    end
    if (en3) begin
      s3_r <= s3_nxt;
    end
  end

  assign dn_valid = s3_v_r;
  assign dn_data  = s3_r;
endmodule

// File: rtl/bpt_corr.sv
// ----------------------------------------------------------------------------
// bpt_corr
// Second-order stages: squares of the cold terms, OFF2/SENS2, and the
// corrected TEMP, OFF and SENS.
// ----------------------------------------------------------------------------
module bpt_corr (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  output logic             up_ready,
  input  bpt_pkg::front_t  up_data,
  output logic             dn_valid,
  input  logic             dn_ready,
  output bpt_pkg::corr_t   dn_data
);
  import bpt_pkg::*;

  logic s4_v_r, s5_v_r, s6_v_r;
  logic en4, en5, en6;

  // stage 4
  logic [A_W-1:0]           b;
  logic signed [SQ_W-1:0]   sq1_p, sq2_p;
  logic [SQ_W-1:0]          sq1_r, sq2_r;
  logic                     cold_r, vcold_r;
  logic [TF_W-1:0]          s4_tf_r;
  logic [RAW_W-1:0]         s4_d1_r;
  logic [OFF1_W-1:0]        s4_off1_r;
  logic [SENS1_W-1:0]       s4_sens1_r;
  // stage 5
  logic [CORR_W-1:0]        sq1_x, sq2_x, f5, f7, f11;
  logic [CORR_W-1:0]        off2_r, sens2_r, off2_nxt, sens2_nxt;
  logic [TF_W-1:0]          s5_tf_r;
  logic [RAW_W-1:0]         s5_d1_r;
  logic [OFF1_W-1:0]        s5_off1_r;
  logic [SENS1_W-1:0]       s5_sens1_r;
  // stage 6
  corr_t                    s6_r, s6_nxt;

  assign en6      = !s6_v_r || dn_ready;
  assign en5      = !s5_v_r || en6;
  assign en4      = !s4_v_r || en5;
  assign up_ready = en4;

  assign b     = up_data.a + A_W'(COLD_OFS);
  assign sq1_p = $signed(up_data.a) * $signed(up_data.a);
  assign sq2_p = $signed(b) * $signed(b);

  assign sq1_x = {{(CORR_W-SQ_W){1'b0}}, sq1_r};
  assign sq2_x = {{(CORR_W-SQ_W){1'b0}}, sq2_r};
  assign f5    = (sq1_x << 2) + sq1_x;
  assign f7    = (sq2_x << 3) - sq2_x;
  assign f11   = (sq2_x << 3) + (sq2_x << 1) + sq2_x;

  always_comb begin
    off2_nxt  = '0;
    sens2_nxt = '0;
    if (cold_r) begin
      off2_nxt  = f5 >> OFF2_SH;
      sens2_nxt = f5 >> SENS2_SH;
    end
    if (vcold_r) begin
      off2_nxt  = off2_nxt + f7;
      sens2_nxt = sens2_nxt + (f11 >> 1);
    end
  end

  always_comb begin
    s6_nxt.d1   = s5_d1_r;
    s6_nxt.tf   = s5_tf_r;
    s6_nxt.off  = {{(OFF_W-OFF1_W){s5_off1_r[OFF1_W-1]}}, s5_off1_r}
                - {1'b0, off2_r};
    s6_nxt.sens = {{(SENS_W-SENS1_W){s5_sens1_r[SENS1_W-1]}}, s5_sens1_r}
                - {1'b0, sens2_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
    end else begin
      if (en4) s4_v_r <= up_valid;
      if (en5) s5_v_r <= s4_v_r;
      if (en6) s6_v_r <= s5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      sq1_r      <= sq1_p;
      sq2_r      <= sq2_p;
      // cold below 20.00 degC, very cold below -15.00 degC
      cold_r     <= up_data.a[A_W-1];
      vcold_r    <= b[A_W-1];
      // T2 only applies when cold
      s4_tf_r    <= {up_data.temp[TEMP_W-1], up_data.temp}
                  - {{(TF_W-T2_W){1'b0}}, up_data.t2 & {T2_W{up_data.a[A_W-1]}}};
      s4_d1_r    <= up_data.d1;
      s4_off1_r  <= up_data.off1;
      s4_sens1_r <= up_data.sens1;
    end
    if (en5) begin
      off2_r     <= off2_nxt;
      sens2_r    <= sens2_nxt;
      s5_tf_r    <= s4_tf_r;
      s5_d1_r    <= s4_d1_r;
      s5_off1_r  <= s4_off1_r;
      s5_sens1_r <= s4_sens1_r;
    end
    if (en6) begin
      s6_r <= s6_nxt;
    end
  end

  assign dn_valid = s6_v_r;
  assign dn_data  = s6_r;
endmodule

// File: rtl/bpt_press.sv
// ----------------------------------------------------------------------------
// bpt_press
// Pressure stages: split D1*SENS multiply, shift and offset, then
// saturation into the output register.
// ----------------------------------------------------------------------------
module bpt_press (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               up_valid,
  output logic                               up_ready,
  input  bpt_pkg::corr_t                     up_data,
  output logic                               dn_valid,
  input  logic                               dn_ready,
  output logic [bpt_pkg::PRES_W-1:0]         pressure,
  output logic signed [bpt_pkg::TOUT_W-1:0]  temperature
);
  import bpt_pkg::*;

  logic s7_v_r, s8_v_r, s9_v_r, s10_v_r;
  logic en7, en8, en9, en10;

  // stage 7
  logic signed [HI_W-1:0]  sens_hi;
  logic [SPLIT_W-1:0]      sens_lo;
  logic [PL_W-1:0]         pl_r, pl_nxt;
  logic signed [PH_W-1:0]  ph_r, ph_nxt;
  logic [OFF_W-1:0]        s7_off_r;
  logic [TF_W-1:0]         s7_tf_r;
  // stage 8
  logic [SUM_W-1:0]        sum;
  logic [PROD_W-1:0]       prod_r;
  logic [OFF_W-1:0]        s8_off_r;
  logic [TF_W-1:0]         s8_tf_r;
  // stage 9
  logic [X_W-1:0]          x_r;
  logic [TF_W-1:0]         s9_tf_r;
  // stage 10
  logic [PRES_W-1:0]       pres_r, pres_nxt;
  logic [TOUT_W-1:0]       temp_r, temp_nxt;
  logic                    t_lo, t_hi;

  assign en10     = !s10_v_r || dn_ready;
  assign en9      = !s9_v_r || en10;
  assign en8      = !s8_v_r || en9;
  assign en7      = !s7_v_r || en8;
  assign up_ready = en7;

  assign sens_hi = up_data.sens[SENS_W-1:SPLIT_W];
  assign sens_lo = up_data.sens[SPLIT_W-1:0];
  assign pl_nxt  = up_data.d1 * sens_lo;
  assign ph_nxt  = $signed({1'b0, up_data.d1}) * sens_hi;

  assign sum = {ph_r, {SPLIT_W{1'b0}}} + {{(SUM_W-PL_W){1'b0}}, pl_r};

  // P = X >>> 15, clamped to the unsigned output range
  always_comb begin
    if (x_r[X_W-1]) begin
      pres_nxt = '0;
    end else if (|x_r[X_W-2:P_SH2+PRES_W]) begin
      pres_nxt = '1;
    end else begin
      pres_nxt = x_r[P_SH2+PRES_W-1:P_SH2];
    end
  end

  assign t_lo = s9_tf_r[TF_W-1] && !(&s9_tf_r[TF_W-2:TOUT_W-1]);
  assign t_hi = !s9_tf_r[TF_W-1] && (|s9_tf_r[TF_W-2:TOUT_W-1]);

  always_comb begin
    if (t_lo) begin
      temp_nxt = {1'b1, {(TOUT_W-1){1'b0}}};
    end else if (t_hi) begin
      temp_nxt = {1'b0, {(TOUT_W-1){1'b1}}};
    end else begin
      temp_nxt = s9_tf_r[TOUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_v_r  <= 1'b0;
      s8_v_r  <= 1'b0;
      s9_v_r  <= 1'b0;
      s10_v_r <= 1'b0;
    end else begin
      if (en7)  s7_v_r  <= up_valid;
      if (en8)  s8_v_r  <= s7_v_r;
      if (en9)  s9_v_r  <= s8_v_r;
      if (en10) s10_v_r <= s9_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en7) begin
      pl_r     <= pl_nxt;
      ph_r     <= ph_nxt;
      s7_off_r <= up_data.off;
      s7_tf_r  <= up_data.tf;
    end
    if (en8) begin
      prod_r   <= sum[SUM_W-1:P_SH1];
      s8_off_r <= s7_off_r;
      s8_tf_r  <= s7_tf_r;
    end
    if (en9) begin
      x_r     <= {prod_r[PROD_W-1], prod_r}
               - {{(X_W-OFF_W){s8_off_r[OFF_W-1]}}, s8_off_r};
      s9_tf_r <= s8_tf_r;
    end
    if (en10) begin
      pres_r <= pres_nxt;
      temp_r <= temp_nxt;
    end
  end

  assign dn_valid    = s10_v_r;
  assign pressure    = pres_r;
  assign temperature = $signed(temp_r);
endmodule

// File: rtl/baro_pressure_temp_compensation_unit.sv
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation_unit
// Second-order barometric pressure and temperature compensation.
// ----------------------------------------------------------------------------
// Usage:
//   Load the six factory coefficients through the cfg_ port (index 0..5:
//   sensitivity, offset, TCS, TCO, reference temperature, temperature
//   coefficient) while the block is idle. Writes to other indexes are dropped.
//   Each item on in_ch carries one raw pressure and one raw temperature
//   conversion; each produces exactly one item on out_ch with pressure in
//   0.01 mbar and temperature in 0.01 degC, both clamped to their ranges.
//   Each item passes three first-order stages, three second-order stages
//   and four pressure stages, the last being the output register. One item
//   is accepted per cycle while out_ch is not stalled, set by the pipeline
//   of multiplier stages.
//   Every stage holds while the one after it is full and stalled; empty
//   stages keep filling, so up to 10 items sit in the pipe while out_ch
//   is held off, and nothing is dropped or repeated.
//   Reset clears all valid bits and the coefficients to zero.
// ----------------------------------------------------------------------------
module baro_pressure_temp_compensation_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  bpt_in_if.sink                         in_ch,
  bpt_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [bpt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bpt_pkg::COEF_W-1:0]     cfg_wdata
);
  import bpt_pkg::*;

  coeff_t coeff;
  front_t front_data;
  corr_t  corr_data;
  logic   front_valid, front_ready;
  logic   corr_valid, corr_ready;

  bpt_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .coeff     (coeff)
  );

  bpt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .coeff    (coeff),
    .up_valid (in_ch.valid),
    .up_ready (in_ch.ready),
    .d1       (in_ch.raw_pressure),
    .d2       (in_ch.raw_temperature),
    .dn_valid (front_valid),
    .dn_ready (front_ready),
    .dn_data  (front_data)
  );

  bpt_corr u_corr (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (front_valid),
    .up_ready (front_ready),
    .up_data  (front_data),
    .dn_valid (corr_valid),
    .dn_ready (corr_ready),
    .dn_data  (corr_data)
  );

  bpt_press u_press (
    .clk         (clk),
    .rst_n       (rst_n),
    .up_valid    (corr_valid),
    .up_ready    (corr_ready),
    .up_data     (corr_data),
    .dn_valid    (out_ch.valid),
    .dn_ready    (out_ch.ready),
    .pressure    (out_ch.pressure_out),
    .temperature (out_ch.temperature_out)
  );
endmodule

// File: rtl/bpt_checker.sv
// ----------------------------------------------------------------------------
// bpt_checker
// Port-level checks on the compensation unit: reset, back-pressure and
// pipeline occupancy.
// ----------------------------------------------------------------------------
module bpt_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [bpt_pkg::PRES_W-1:0]         pressure_out,
  input logic signed [bpt_pkg::TOUT_W-1:0]  temperature_out
);
  import bpt_pkg::*;

  localparam int OCC_W = $clog2(PIPE_DEPTH + 1);

  logic             in_acc, out_acc;
  logic [OCC_W-1:0] occ_r, occ_nxt;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_comb begin
    occ_nxt = occ_r;
    if (in_acc && !out_acc) begin
      occ_nxt = occ_r + OCC_W'(1);
    end else if (!in_acc && out_acc) begin
      occ_nxt = occ_r - OCC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input held off although the output side can move");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(PIPE_DEPTH))
    else $error("more items in flight than pipeline stages");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> occ_r != '0)
    else $error("result offered with no item in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(pressure_out) && $stable(temperature_out)))
    else $error("stalled result changed");
endmodule

bind baro_pressure_temp_compensation_unit bpt_checker u_bpt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .pressure_out    (out_ch.pressure_out),
  .temperature_out (out_ch.temperature_out)
);

// File: tb/baro_pressure_temp_compensation_unit_tb.sv
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation_unit_tb
// Sends raw pressure/temperature pairs through the compensation pipeline
// under several coefficient sets and flow-control patterns. Each compensated
// reading is predicted in 64-bit arithmetic and every output item is checked
// in order against it.
// ----------------------------------------------------------------------------
module baro_pressure_temp_compensation_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bpt_pkg::*;

  localparam longint ROOM_TEMP      = 2000;
  localparam longint VERY_COLD_TEMP = -1500;
  localparam longint PRES_CEIL      = 262143;
  localparam longint TEMP_FLOOR     = -32768;
  localparam longint TEMP_CEIL      = 32767;
  localparam longint RAW_CEIL       = (64'd1 << RAW_W) - 1;
  localparam int     CYCLE_LIMIT    = 400000;
  localparam int     ITEMS_PER_FLOW = 240;
  localparam int     SETTLE_CYCLES  = PIPE_DEPTH + 4;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  localparam coeff_t NOMINAL_COEFFS = '{sens: 16'd40127, offset: 16'd36924,
                                        tcs: 16'd23317, tco: 16'd23282,
                                        tref: 16'd33464, tempsens: 16'd28312};
  localparam coeff_t MAX_COEFFS  = '{default: 16'hFFFF};
  localparam coeff_t ZERO_COEFFS = '{default: 16'h0000};

  typedef struct {
    logic [PRES_W-1:0]        pressure;
    logic signed [TOUT_W-1:0] temperature;
  } reading_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COEF_W-1:0]    cfg_wdata;

  bpt_in_if  in_ch();
  bpt_out_if out_ch();

  coeff_t   coeffs;                 // copy of the block's coefficient registers
  reading_t pending_readings[$];
  int       mismatches     = 0;
  int       cycle_count    = 0;
  int       send_idle_pct  = 0;
  int       recv_stall_pct = 0;

  baro_pressure_temp_compensation_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic [RAW_W-1:0] clamp_raw(input longint value);
    longint v;
    v = value;
    if (v < 0) begin
      v = 0;
    end else if (v > RAW_CEIL) begin
      v = RAW_CEIL;
    end
    return v[RAW_W-1:0];
  endfunction

  function automatic reading_t compensate(input logic [RAW_W-1:0] d1_raw,
                                          input logic [RAW_W-1:0] d2_raw,
                                          input coeff_t c);
    longint   d1, dt, temp, off, sens, t2, off2, sens2, sq, p;
    reading_t r;
    d1    = longint'(d1_raw);
    dt    = longint'(d2_raw) - longint'(c.tref) * 256;
    temp  = ROOM_TEMP + ((dt * longint'(c.tempsens)) >>> 23);
    off   = longint'(c.offset) * 65536 + ((longint'(c.tco) * dt) >>> 7);
    sens  = longint'(c.sens) * 32768 + ((longint'(c.tcs) * dt) >>> 8);
    t2    = 0;
    off2  = 0;
    sens2 = 0;
    // second-order terms are chosen on the first-order temperature
    if (temp < ROOM_TEMP) begin
      t2    = (dt * dt) >>> 31;
      sq    = 5 * (temp - ROOM_TEMP) * (temp - ROOM_TEMP);
      off2  = sq >>> 1;
      sens2 = sq >>> 2;
      if (temp < VERY_COLD_TEMP) begin
        sq    = (temp - VERY_COLD_TEMP) * (temp - VERY_COLD_TEMP);
        off2  = off2 + 7 * sq;
        sens2 = sens2 + ((11 * sq) >>> 1);
      end
    end
    temp = temp - t2;
    off  = off - off2;
    sens = sens - sens2;
    p    = (((d1 * sens) >>> 21) - off) >>> 15;
    if (p < 0) begin
      p = 0;
    end else if (p > PRES_CEIL) begin
      p = PRES_CEIL;
    end
    if (temp < TEMP_FLOOR) begin
      temp = TEMP_FLOOR;
    end else if (temp > TEMP_CEIL) begin
      temp = TEMP_CEIL;
    end
    r.pressure    = p[PRES_W-1:0];
    r.temperature = temp[TOUT_W-1:0];
    return r;
  endfunction

  // Smallest raw temperature whose first-order TEMP is ROOM_TEMP + delta.
  function automatic logic [RAW_W-1:0] raw_temp_for(input longint delta);
    longint c6, n, dt;
    c6 = longint'(coeffs.tempsens);
    n  = delta <<< 23;
    dt = (n < 0) ? n / c6 : (n + c6 - 1) / c6;
    return clamp_raw(longint'(coeffs.tref) * 256 + dt);
  endfunction

  function automatic coeff_t random_coeffs();
    coeff_t c;
    c.sens     = COEF_W'($urandom);
    c.offset   = COEF_W'($urandom);
    c.tcs      = COEF_W'($urandom);
    c.tco      = COEF_W'($urandom);
    c.tref     = COEF_W'($urandom);
    c.tempsens = COEF_W'($urandom);
    return c;
  endfunction

  // Receiver: random back-pressure and in-order checking of each output item.
  initial begin
    reading_t want;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (pending_readings.size() == 0) begin
          $display("%0t: output item with nothing pending: pressure %0d temperature %0d",
                   $time, out_ch.pressure_out, out_ch.temperature_out);
          mismatches++;
        end else begin
          want = pending_readings.pop_front();
          if (out_ch.pressure_out !== want.pressure) begin
            $display("%0t: pressure mismatch: expected %0d, actual %0d",
                     $time, want.pressure, out_ch.pressure_out);
            mismatches++;
          end
          if (out_ch.temperature_out !== want.temperature) begin
            $display("%0t: temperature mismatch: expected %0d, actual %0d",
                     $time, want.temperature, out_ch.temperature_out);
            mismatches++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic send_pair(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_ch.valid           <= 1'b1;
    in_ch.raw_pressure    <= d1;
    in_ch.raw_temperature <= d2;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    pending_readings.push_back(compensate(d1, d2, coeffs));
  endtask

  // Drop valid, wait for every pending reading, then let the pipe run empty.
  task automatic settle_pipeline();
    in_ch.valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_coeff(input logic [CFG_IDX_W-1:0] idx,
                             input logic [COEF_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      CFG_SENS:     coeffs.sens     = value;
      CFG_OFFSET:   coeffs.offset   = value;
      CFG_TCS:      coeffs.tcs      = value;
      CFG_TCO:      coeffs.tco      = value;
      CFG_TREF:     coeffs.tref     = value;
      CFG_TEMPSENS: coeffs.tempsens = value;
      default:      ;  // spare indexes are dropped by the block
    endcase
  endtask

  task automatic load_coeffs(input coeff_t c);
    settle_pipeline();
    write_coeff(CFG_SENS, c.sens);
    write_coeff(CFG_OFFSET, c.offset);
    write_coeff(CFG_TCS, c.tcs);
    write_coeff(CFG_TCO, c.tco);
    write_coeff(CFG_TREF, c.tref);
    write_coeff(CFG_TEMPSENS, c.tempsens);
    cfg_we <= 1'b0;
  endtask

  // About half the pairs sit near the reference temperature, the rest span the full range.
  task automatic stream_random(input int count);
    logic [RAW_W-1:0] d1, d2;
    longint           spread;
    repeat (count) begin
      d1 = RAW_W'($urandom);
      if ($urandom_range(0, 1) == 1) begin
        d2 = RAW_W'($urandom);
      end else begin
        spread = longint'($urandom_range(0, 1 << 21)) - (1 << 20);
        d2     = clamp_raw(longint'(coeffs.tref) * 256 + spread);
      end
      send_pair(d1, d2);
    end
  endtask

  task automatic test_reset_coeffs();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_pair('0, '0);
    send_pair('1, '1);
  endtask

  task automatic test_temperature_bands();
    load_coeffs(NOMINAL_COEFFS);
    send_pair(24'd9085466, 24'd8569150);
    send_pair(24'd9085466, raw_temp_for(0));      // exactly 20.00 degC
    send_pair(24'd9085466, raw_temp_for(-1));     // just cold
    send_pair(24'd9085466, raw_temp_for(-3500));  // -15.00 degC, still only cold
    send_pair(24'd9085466, raw_temp_for(-3501));  // just very cold
    send_pair(24'd9085466, '0);
    send_pair(24'd9085466, '1);
    send_pair('0, 24'd8569150);
    send_pair('1, 24'd8569150);
  endtask

  task automatic test_spare_index();
    settle_pipeline();
    write_coeff(CFG_SPARE_LO, 16'hFFFF);
    write_coeff(CFG_SPARE_HI, 16'h5A5A);
    cfg_we <= 1'b0;
    send_pair(24'd9085466, 24'd8569150);
  endtask

  task automatic test_saturation();
    load_coeffs(MAX_COEFFS);
    send_pair('1, '1);
    send_pair('1, '0);
    send_pair('0, '1);
    send_pair('0, '0);
    send_pair(24'h800000, 24'h7FFFFF);
    load_coeffs(ZERO_COEFFS);
    send_pair('1, '1);
    send_pair(24'h555555, 24'hAAAAAA);
  endtask

  task automatic test_streaming_no_idle();
    load_coeffs(NOMINAL_COEFFS);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    stream_random(ITEMS_PER_FLOW);
  endtask

  task automatic test_sender_gaps();
    load_coeffs(random_coeffs());
    send_idle_pct  = 76;
    recv_stall_pct = 0;
    stream_random(ITEMS_PER_FLOW);
  endtask

  task automatic test_receiver_stalls();
    load_coeffs(random_coeffs());
    send_idle_pct  = 0;
    recv_stall_pct = 76;
    stream_random(ITEMS_PER_FLOW);
  endtask

  task automatic test_mixed_flow();
    load_coeffs(NOMINAL_COEFFS);
    send_idle_pct  = 32;
    recv_stall_pct = 32;
    stream_random(ITEMS_PER_FLOW);
  endtask

  initial begin
    coeffs                = ZERO_COEFFS;
    rst_n                 <= 1'b0;
    cfg_we                <= 1'b0;
    cfg_index             <= CFG_SENS;
    cfg_wdata             <= '0;
    in_ch.valid           <= 1'b0;
    in_ch.raw_pressure    <= '0;
    in_ch.raw_temperature <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_coeffs();
    test_temperature_bands();
    test_spare_index();
    test_saturation();
    test_streaming_no_idle();
    test_sender_gaps();
    test_receiver_stalls();
    test_mixed_flow();

    settle_pipeline();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
